/* rtl/oaht_pkg.sv */
// Shared types, codes and constants of the open-address hash table.
package oaht_pkg;

  // Default geometry of the table and of the double-hash step.
  localparam int unsigned TableSizeDef = 1021;
  localparam int unsigned StepPrimeDef = 17;

  // Fixed field widths of the transfer payloads.
  localparam int unsigned CmdW = 2;
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 3;
  localparam int unsigned OccW = 10;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_REMOVED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic probe_start;
    logic eval;
    logic commit;
  } oaht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic probe_stop;
    logic out_free;
  } oaht_stat_t;

endpackage

/* rtl/open_address_hash_table.sv */
// Top level of the open-address hash table: controller plus datapath.
//
// Key/value table with TABLE_SIZE slots, open addressing and tombstones. An
// operation is transferred in and passes the hash unit (a reciprocal
// multiplication at the transfer, a multiply and subtract, then a final
// compare and subtract for both remainders). Each probed slot then takes a
// registered read of the slot memories and then a compare, and a commit ends
// the operation. The single read port of the slot memories sets the probe
// pace. After reset the tag memory is cleared one slot a cycle, during which
// no operation is accepted; probe_mode writes are taken at any time. The next
// operation is accepted while a result still waits in the output register.
module open_address_hash_table
  import oaht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef,
  parameter int unsigned STEP_PRIME = StepPrimeDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [KeyW-1:0]        key_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [StW-1:0]         status_o,
  output logic signed [ValW-1:0] found_value_o,
  output logic [OccW-1:0]        occupancy_o
);

  oaht_cmd_t  cmd;
  oaht_stat_t stat;

  oaht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  oaht_dp #(
    .TABLE_SIZE(TABLE_SIZE),
    .STEP_PRIME(STEP_PRIME)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (cmd_i),
    .in_key_i     (key_i),
    .in_value_i   (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .occupancy_o  (occupancy_o)
  );

endmodule

/* rtl/oaht_hash.sv */
// Pipelined hash unit: home slot and probe step of a key by reciprocal multiplication.
module oaht_hash
  import oaht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef,
  parameter int unsigned STEP_PRIME = StepPrimeDef,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE),
  localparam int unsigned PrW  = $clog2(STEP_PRIME),
  localparam int unsigned SwW  = $clog2(STEP_PRIME + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [KeyW-1:0] key_i,
  input  logic            mode_i,
  output logic            done_o,
  output logic [IdxW-1:0] home_o,
  output logic [SwW-1:0]  step_o
);

  // Reciprocals scaled by 2^KeyW; the quotient estimate is low by at most one.
  localparam logic [KeyW-1:0] RecipN = KeyW'((64'd1 << KeyW) / TABLE_SIZE);
  localparam logic [KeyW-1:0] RecipP = KeyW'((64'd1 << KeyW) / STEP_PRIME);
  localparam logic [KeyW-1:0] NKey   = KeyW'(TABLE_SIZE);
  localparam logic [KeyW-1:0] PKey   = KeyW'(STEP_PRIME);
  localparam logic [IdxW:0]   NExt   = (IdxW + 1)'(TABLE_SIZE);
  localparam logic [PrW:0]    PExt   = (PrW + 1)'(STEP_PRIME);

  logic              s1_q, s2_q;
  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   quo_n_q, quo_p_q;
  logic [IdxW:0]     part_n_q;
  logic [PrW:0]      part_p_q;
  logic [IdxW-1:0]   rem_n_q;
  logic [PrW-1:0]    rem_p_q;
  logic [2*KeyW-1:0] prod_n, prod_p;
  logic [KeyW-1:0]   diff_n, diff_p;
  logic [IdxW:0]     sub_n;
  logic [PrW:0]      sub_p;

  // Quotient estimates, partial remainders below twice the divisor, final fix-up.
  always_comb begin
    prod_n = {{KeyW{1'b0}}, key_i} * {{KeyW{1'b0}}, RecipN};
    prod_p = {{KeyW{1'b0}}, key_i} * {{KeyW{1'b0}}, RecipP};
    diff_n = key_q - quo_n_q * NKey;
    diff_p = key_q - quo_p_q * PKey;
    sub_n  = part_n_q - NExt;
    sub_p  = part_p_q - PExt;
  end

  // Stage flags of the three-step reduction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= start_i;
      s2_q <= s1_q;
    end
  end

  // Stage registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q   <= key_i;
      quo_n_q <= prod_n[2*KeyW-1:KeyW];
      quo_p_q <= prod_p[2*KeyW-1:KeyW];
    end
    if (s1_q) begin
      part_n_q <= diff_n[IdxW:0];
      part_p_q <= diff_p[PrW:0];
    end
    if (s2_q) begin
      rem_n_q <= (part_n_q >= NExt) ? sub_n[IdxW-1:0] : part_n_q[IdxW-1:0];
      rem_p_q <= (part_p_q >= PExt) ? sub_p[PrW-1:0] : part_p_q[PrW-1:0];
    end
  end

  assign done_o = !s1_q && !s2_q;
  assign home_o = rem_n_q;
  assign step_o = mode_i ? (SwW'(STEP_PRIME) - SwW'(rem_p_q)) : SwW'(1);

endmodule

/* rtl/oaht_dp.sv */
// Datapath: slot memories, probe registers, occupancy count and result register.
module oaht_dp
  import oaht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef,
  parameter int unsigned STEP_PRIME = StepPrimeDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  oaht_cmd_t              cmd_i,
  output oaht_stat_t             stat_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  input  logic [CmdW-1:0]        in_cmd_i,
  input  logic [KeyW-1:0]        in_key_i,
  input  logic signed [ValW-1:0] in_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [StW-1:0]         status_o,
  output logic signed [ValW-1:0] found_value_o,
  output logic [OccW-1:0]        occupancy_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);
  localparam int unsigned SwW  = $clog2(STEP_PRIME + 1);
  localparam int unsigned CntW = $clog2(TABLE_SIZE + 1);
  localparam logic [IdxW:0]   NExt = (IdxW + 1)'(TABLE_SIZE);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SIZE - 1);

  // Slot memories.
  logic [1:0]      tag_mem  [TABLE_SIZE];
  logic [KeyW-1:0] key_mem  [TABLE_SIZE];
  logic [ValW-1:0] data_mem [TABLE_SIZE];

  logic                   mode_q;
  logic [CmdW-1:0]        cmd_q;
  logic [KeyW-1:0]        key_q;
  logic signed [ValW-1:0] val_q;
  logic [IdxW-1:0]        clr_q;
  logic [IdxW-1:0]        idx_q;
  logic [IdxW-1:0]        free_q;
  logic                   free_vld_q;
  logic                   hit_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [1:0]             tag_rd_q;
  logic [KeyW-1:0]        key_rd_q;
  logic [ValW-1:0]        data_rd_q;
  logic                   out_valid_q;
  logic [StW-1:0]         out_st_q;
  logic signed [ValW-1:0] out_found_q;
  logic [OccW-1:0]        out_occ_q;

  logic            hash_done;
  logic [IdxW-1:0] home;
  logic [SwW-1:0]  step;
  logic [IdxW:0]   nxt_sum;
  logic [IdxW-1:0] nxt;
  logic            is_empty, is_used, is_match;
  logic            ins_new, ins_rep, del_hit;
  logic            tag_we;
  logic [IdxW-1:0] tag_wa;
  logic [1:0]      tag_wd;
  logic            key_we, data_we;
  logic [IdxW-1:0] data_wa;
  logic [StW-1:0]  st_d;
  logic [CntW+OccW-1:0] occ_ext;

  oaht_hash #(
    .TABLE_SIZE(TABLE_SIZE),
    .STEP_PRIME(STEP_PRIME)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.load),
    .key_i  (in_key_i),
    .mode_i (mode_q),
    .done_o (hash_done),
    .home_o (home),
    .step_o (step)
  );

  // Probe mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  // Classification of the slot that was just read, and the next probe slot.
  always_comb begin
    is_empty = (tag_rd_q == TAG_EMPTY);
    is_used  = (tag_rd_q == TAG_USED);
    is_match = is_used && (key_rd_q == key_q);
    nxt_sum  = {1'b0, idx_q} + (IdxW + 1)'(step);
    if (nxt_sum >= NExt) begin
      nxt_sum = nxt_sum - NExt;
    end
    nxt = nxt_sum[IdxW-1:0];
  end

  // Probe walk: current slot, first free slot and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      free_q     <= '0;
      free_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else if (cmd_i.probe_start) begin
      idx_q      <= home;
      free_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else if (cmd_i.eval) begin
      if (!is_used && !free_vld_q) begin
        free_q     <= idx_q;
        free_vld_q <= 1'b1;
      end
      if (is_match) begin
        hit_q <= 1'b1;
      end
      if (!is_empty && !is_match) begin
        idx_q <= nxt;
      end
    end
  end

  // Clearing pass over the tag memory after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + IdxW'(1);
    end
  end

  // Outcome of the operation and the write ports.
  always_comb begin
    ins_new = (cmd_q == CMD_INSERT) && !hit_q && free_vld_q;
    ins_rep = (cmd_q == CMD_INSERT) && hit_q;
    del_hit = (cmd_q == CMD_DELETE) && hit_q;

    case (cmd_q)
      CMD_INSERT: st_d = hit_q ? ST_REPLACED : (free_vld_q ? ST_INSERTED : ST_FULL);
      CMD_LOOKUP: st_d = hit_q ? ST_HIT : ST_MISS;
      CMD_DELETE: st_d = hit_q ? ST_REMOVED : ST_MISS;
      default:    st_d = ST_MISS;
    endcase

    cnt_d = cnt_q;
    if (ins_new) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (del_hit && (cnt_q != '0)) begin
      cnt_d = cnt_q - CntW'(1);
    end

    tag_we = 1'b0;
    tag_wa = clr_q;
    tag_wd = TAG_EMPTY;
    if (cmd_i.clr_step) begin
      tag_we = 1'b1;
    end else if (cmd_i.commit && ins_new) begin
      tag_we = 1'b1;
      tag_wa = free_q;
      tag_wd = TAG_USED;
    end else if (cmd_i.commit && del_hit) begin
      tag_we = 1'b1;
      tag_wa = idx_q;
      tag_wd = TAG_TOMB;
    end

    key_we  = cmd_i.commit && ins_new;
    data_we = cmd_i.commit && (ins_new || ins_rep);
    data_wa = hit_q ? idx_q : free_q;
    occ_ext = {{OccW{1'b0}}, cnt_d};
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_rd_q <= tag_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[free_q] <= key_q;
    end
    key_rd_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= val_q;
    end
    data_rd_q <= data_mem[idx_q];
  end

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register; a new result loads only once the previous one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_st_q    <= st_d;
      out_found_q <= ((cmd_q == CMD_LOOKUP) && hit_q) ? data_rd_q : '0;
      out_occ_q   <= occ_ext[OccW-1:0];
    end
  end

  assign stat_o.clr_last   = (clr_q == LastIdx);
  assign stat_o.hash_done  = hash_done;
  assign stat_o.probe_stop = is_empty || is_match || (nxt == home);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign found_value_o = out_found_q;
  assign occupancy_o   = out_occ_q;

  // The count can never exceed the number of slots.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_SIZE))
    else $error("occupancy count exceeds table size");

  // A result is only written over a slot that is empty or being drained.
  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // Every finished operation presents a result in the next cycle.
  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("finished operation produced no result");

  // A new slot is only filled when the probe found a free one.
  a_fill_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (cmd_q == CMD_INSERT) && !hit_q && (st_d == ST_INSERTED))
      |-> free_vld_q)
    else $error("insert without a free slot");

endmodule

/* rtl/oaht_ctrl.sv */
// Controller state machine that sequences clear, hash, probe and commit.
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  oaht_stat_t stat_i,
  output oaht_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          cmd_o.probe_start = 1'b1;
          state_d           = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.probe_stop ? S_COMMIT : S_READ;
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* sim/tb_open_address_hash_table.sv */
// Self-checking testbench for the open-address hash table top level.
`timescale 1ns / 100ps

module tb_open_address_hash_table;
  import oaht_pkg::*;

  localparam int          PressureCycles = 300;
  localparam int          TailCycles     = 40;
  localparam int          MaxReports     = 10;

  // The two-bit command field has one code with no operation behind it.
  localparam logic [CmdW-1:0] CmdUndef = 2'd3;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [ValW-1:0] found;
    logic [OccW-1:0] occ;
  } table_result_t;

  typedef struct packed {
    logic            mode;
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            typed;
    table_result_t   res;
  } dir_row_t;

  // Block inputs, all at known values from time zero.
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_data_i    = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [CmdW-1:0]        cmd_i         = '0;
  logic [KeyW-1:0]        key_i         = '0;
  logic signed [ValW-1:0] value_i       = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic [StW-1:0]         status_o;
  logic signed [ValW-1:0] found_value_o;
  logic [OccW-1:0]        occupancy_o;

  // Shadow copy of the slot memories and the probe setting.
  tag_e            tbl_tag [TableSizeDef];
  logic [KeyW-1:0] tbl_key [TableSizeDef];
  logic [ValW-1:0] tbl_val [TableSizeDef];
  logic [10:0]     tbl_count  = '0;
  logic            tbl_double = 1'b0;

  table_result_t   pending_results[$];
  dir_row_t        dir_rows[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  logic hold_go       = 1'b0;
  int  hold_left      = 0;
  int  err_count      = 0;
  int  op_count       = 0;
  int  result_count   = 0;
  int  status_tally [6];

  open_address_hash_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .occupancy_o  (occupancy_o)
  );

  always #10 clk_i = ~clk_i;

  // Walk the probe sequence of a key. Returns 1 on a match in an occupied slot;
  // free_slot gets the first tombstone or empty slot seen, or -1.
  function automatic bit search_key(input logic [KeyW-1:0] key, output int hit,
                                    output int free_slot);
    int unsigned home;
    int unsigned stride;
    int unsigned idx;
    int unsigned n;
    bit found;
    home = key % TableSizeDef;
    stride = tbl_double ? (StepPrimeDef - (key % StepPrimeDef)) : 1;
    stride = stride % TableSizeDef;
    idx = home;
    hit = -1;
    free_slot = -1;
    found = 1'b0;
    for (n = 0; n < TableSizeDef; n++) begin
      if (tbl_tag[idx] == TAG_EMPTY) begin
        if (free_slot < 0) free_slot = int'(idx);
        break;
      end
      if (tbl_tag[idx] == TAG_USED) begin
        if (tbl_key[idx] == key) begin
          hit = int'(idx);
          found = 1'b1;
          break;
        end
      end else if (free_slot < 0) begin
        free_slot = int'(idx);
      end
      idx = (idx + stride) % TableSizeDef;
      if (idx == home) break;
    end
    return found;
  endfunction

  // Apply one operation to the shadow table and return the result it gives.
  function automatic table_result_t apply_op(input logic [CmdW-1:0] cmd,
                                             input logic [KeyW-1:0] key,
                                             input logic [ValW-1:0] value);
    table_result_t r;
    int hit;
    int free_slot;
    bit found;
    r.status = ST_MISS;
    r.found = '0;
    found = search_key(key, hit, free_slot);
    case (cmd)
      CMD_INSERT: begin
        if (found) begin
          tbl_val[hit] = value;
          r.status = ST_REPLACED;
        end else if (free_slot >= 0) begin
          tbl_tag[free_slot] = TAG_USED;
          tbl_key[free_slot] = key;
          tbl_val[free_slot] = value;
          tbl_count = tbl_count + 11'd1;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (found) begin
          r.found = tbl_val[hit];
          r.status = ST_HIT;
        end
      end
      CMD_DELETE: begin
        if (found) begin
          tbl_tag[hit] = TAG_TOMB;
          tbl_key[hit] = '0;
          tbl_val[hit] = '0;
          if (tbl_count > 0) tbl_count = tbl_count - 11'd1;
          r.status = ST_REMOVED;
        end
      end
      default: ;
    endcase
    r.occ = tbl_count[OccW-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input table_result_t want,
                               input table_result_t got);
    err_count++;
    if (err_count <= MaxReports) begin
      $display("%0t mismatch (%s): expected status %0d value %h occupancy %0d,",
               $realtime, what, want.status, want.found, want.occ);
      $display("    got status %0d value %h occupancy %0d", got.status, got.found, got.occ);
    end
  endtask

  // Offer one operation and wait for its transfer; predict at acceptance.
  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key,
                         input logic [ValW-1:0] value, input logic typed,
                         input table_result_t typed_res);
    table_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= key;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_op(cmd, key, value);
    op_count++;
    if (typed) begin
      if (predicted !== typed_res) note_mismatch("predictor", typed_res, predicted);
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(predicted);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Probe mode is only changed with the table idle.
  task automatic set_probe_mode(input logic mode);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tbl_double = mode;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic add_row(input logic mode, input logic [CmdW-1:0] cmd,
                         input logic [KeyW-1:0] key, input logic [ValW-1:0] value,
                         input logic typed, input logic [StW-1:0] st,
                         input logic [ValW-1:0] found, input logic [OccW-1:0] occ);
    dir_row_t row;
    row.mode   = mode;
    row.cmd    = cmd;
    row.key    = key;
    row.value  = value;
    row.typed  = typed;
    row.res    = '{status: st, found: found, occ: occ};
    dir_rows.push_back(row);
  endtask

  // Random operation: mostly keys that pile up on home slots 0 to 47, some
  // keys from the whole range, and the key extremes now and then.
  task automatic random_op;
    int unsigned pick;
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_INSERT;
    else if (pick < 75) cmd = CMD_LOOKUP;
    else if (pick < 95) cmd = CMD_DELETE;
    else cmd = CmdUndef;
    pick = $urandom_range(0, 99);
    if (pick < 70) key = KeyW'($urandom_range(0, 47) + TableSizeDef * $urandom_range(0, 5));
    else if (pick < 95) key = KeyW'($urandom);
    else key = pick[0] ? '1 : '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) value = 32'h8000_0000;
    else if (pick == 1) value = 32'h7FFF_FFFF;
    else value = $urandom;
    send_op(cmd, key, value, 1'b0, '0);
  endtask

  task automatic random_phase(input logic mode, input int send_pct, input int recv_pct,
                              input int count);
    set_probe_mode(mode);
    set_idling(send_pct, recv_pct);
    repeat (count) random_op();
  endtask

  // Result side: random stalls, a long hold-off on request, and the checker.
  always @(posedge clk_i) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {status_o, found_value_o, occupancy_o};
      result_count++;
      if (got.status < 6) status_tally[got.status]++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t unexpected result: status %0d value %h occupancy %0d",
                   $realtime, got.status, got.found, got.occ);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result", want, got);
      end
    end
    if (hold_go) hold_left = PressureCycles;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Run time limit, far beyond the slowest legal run.
  initial begin
    #(400_000_000);
    $display("** open_address_hash_table: FAILED **");
    $finish;
  end

  initial begin : stimulus
    foreach (tbl_tag[i]) begin
      tbl_tag[i] = TAG_EMPTY;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    foreach (status_tally[i]) status_tally[i] = 0;

    // Directed rows: extremes, collisions, tombstones, the undefined command,
    // then double hashing over a table laid out by linear probing.
    add_row(0, CMD_LOOKUP, 0, 32'hFFFF_FFFF, 1, ST_MISS, 0, 0);
    add_row(0, CMD_DELETE, 5, 32'h0, 1, ST_MISS, 0, 0);
    add_row(0, CMD_INSERT, 0, 32'h8000_0000, 1, ST_INSERTED, 0, 1);
    add_row(0, CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1, ST_INSERTED, 0, 2);
    add_row(0, CMD_LOOKUP, 0, 32'h0, 1, ST_HIT, 32'h8000_0000, 2);
    add_row(0, CMD_INSERT, 0, 32'hFFFF_FFFF, 1, ST_REPLACED, 0, 2);
    add_row(0, CMD_INSERT, 1021, 32'h1, 1, ST_INSERTED, 0, 3);
    add_row(0, CMD_INSERT, 2042, 32'h2, 1, ST_INSERTED, 0, 4);
    add_row(0, CMD_DELETE, 1021, 32'h0, 1, ST_REMOVED, 0, 3);
    add_row(0, CMD_LOOKUP, 2042, 32'h0, 1, ST_HIT, 32'h2, 3);
    add_row(0, CMD_LOOKUP, 1021, 32'h0, 1, ST_MISS, 0, 3);
    add_row(0, CMD_INSERT, 3063, 32'h3, 1, ST_INSERTED, 0, 4);
    add_row(0, CmdUndef, 0, 32'h1234_5678, 1, ST_MISS, 0, 4);
    add_row(0, CMD_INSERT, 1, 32'h5, 1, ST_INSERTED, 0, 5);
    add_row(0, CMD_LOOKUP, 31'h7FFF_FFFF, 32'h0, 1, ST_HIT, 32'h7FFF_FFFF, 5);
    add_row(0, CMD_DELETE, 0, 32'h0, 1, ST_REMOVED, 0, 4);
    add_row(0, CMD_DELETE, 0, 32'h0, 1, ST_MISS, 0, 4);
    add_row(1, CMD_INSERT, 17, 32'h5555_5555, 1, ST_INSERTED, 0, 5);
    add_row(1, CMD_INSERT, 1038, 32'hAAAA_AAAA, 0, 0, 0, 0);
    add_row(1, CMD_LOOKUP, 1038, 32'h0, 0, 0, 0, 0);
    add_row(1, CMD_INSERT, 2059, 32'h0F0F_0F0F, 0, 0, 0, 0);
    add_row(1, CMD_DELETE, 1038, 32'h0, 0, 0, 0, 0);
    add_row(1, CMD_LOOKUP, 2059, 32'h0, 0, 0, 0, 0);
    add_row(1, CMD_INSERT, 34, 32'h0, 0, 0, 0, 0);
    add_row(1, CMD_LOOKUP, 1, 32'h0, 0, 0, 0, 0);

    // Single reset; the block clears its tags before it takes a transfer.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_probe_mode(1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != tbl_double) set_probe_mode(dir_rows[i].mode);
      send_op(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value, dir_rows[i].typed,
              dir_rows[i].res);
    end

    // Random phases across both probe modes and all idling patterns.
    random_phase(1'b0, 0, 0, 110);
    random_phase(1'b1, 46, 0, 110);
    random_phase(1'b0, 0, 46, 110);

    // Long hold-off on the result side while operations keep coming.
    set_probe_mode(1'b1);
    set_idling(0, 0);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    repeat (30) random_op();

    random_phase(1'b0, 15, 15, 100);
    random_phase(1'b1, 15, 15, 60);

    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d operations and took %0d results in both probe modes, with a long",
             op_count, result_count);
    $display("  hold-off and random idling; ins %0d rep %0d full %0d hit %0d miss %0d rem %0d",
             status_tally[ST_INSERTED], status_tally[ST_REPLACED],
             status_tally[ST_FULL], status_tally[ST_HIT], status_tally[ST_MISS],
             status_tally[ST_REMOVED]);
    if (err_count == 0) begin
      $display("** open_address_hash_table: PASSED **");
    end else begin
      $display("** open_address_hash_table: FAILED **");
    end
    $finish;
  end

endmodule
